>>> rtl/i2cram_pkg.sv
// ----------------------------------------------------------------------------
// I2C register access master package
// Shared payload types, command codes and sequencer phase codes.
// ----------------------------------------------------------------------------
package i2cram_pkg;

    typedef logic [4:0] t_phase;
    typedef logic [1:0] t_kind;

    localparam t_kind KIND_TICK  = 2'd0;
    localparam t_kind KIND_WRITE = 2'd1;
    localparam t_kind KIND_READ  = 2'd2;

    localparam t_phase PH_IDLE       = 5'd0;
    localparam t_phase PH_ST_HIGH    = 5'd1;
    localparam t_phase PH_ST_LOW     = 5'd2;
    localparam t_phase PH_RS_PREP    = 5'd3;
    localparam t_phase PH_TX_SETUP   = 5'd4;
    localparam t_phase PH_TX_HIGH    = 5'd5;
    localparam t_phase PH_TX_LOW     = 5'd6;
    localparam t_phase PH_ACK_REL    = 5'd7;
    localparam t_phase PH_ACK_HIGH   = 5'd8;
    localparam t_phase PH_ACK_POLL   = 5'd9;
    localparam t_phase PH_RX_LOW     = 5'd10;
    localparam t_phase PH_RX_HIGH    = 5'd11;
    localparam t_phase PH_NACK_SETUP = 5'd12;
    localparam t_phase PH_NACK_HIGH  = 5'd13;
    localparam t_phase PH_SP_LOW     = 5'd14;
    localparam t_phase PH_SP_HIGH    = 5'd15;
    localparam t_phase PH_SP_DONE    = 5'd16;
    localparam t_phase PH_SPE_LOW    = 5'd17;
    localparam t_phase PH_SPE_HIGH   = 5'd18;
    localparam t_phase PH_SPE_DONE   = 5'd19;

    localparam logic CFG_TICKS_PER_US  = 1'b0;
    localparam logic CFG_ACK_TIMEOUT   = 1'b1;

    localparam logic [15:0] TICKS_PER_US_RESET = 16'd50;
    localparam logic [15:0] ACK_TIMEOUT_RESET  = 16'd250;

    typedef struct packed {
        t_kind      kind;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic       sda_in;
    } t_in_payload;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive_enable;
        logic       busy_res;
        logic       done_res;
        logic       ack_error;
        logic [7:0] read_data;
    } t_out_payload;

endpackage

>>> rtl/i2cram_in_if.sv
// ----------------------------------------------------------------------------
// I2C register access master input channel
// Valid/ready channel that carries one command and SDA sample per tick.
// ----------------------------------------------------------------------------
interface i2cram_in_if
    import i2cram_pkg::*;
    ();
    logic        valid;
    logic        ready;
    t_in_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/i2cram_out_if.sv
// ----------------------------------------------------------------------------
// I2C register access master output channel
// Valid/ready channel that carries the bus levels and status of one tick.
// ----------------------------------------------------------------------------
interface i2cram_out_if
    import i2cram_pkg::*;
    ();
    logic         valid;
    logic         ready;
    t_out_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/i2c_register_access_master_core.sv
// ----------------------------------------------------------------------------
// I2C register access master core
// Bus timing sequencer for single register writes and reads.
// ----------------------------------------------------------------------------
// Each input transaction is one tick of the bus sequencer and yields exactly
// one output transaction with the SCL/SDA drive levels and status after that
// tick. The core takes one input transaction per clock cycle: the next state
// and the result are formed in one pass of logic and stored in the state
// registers and a single output register, and a new input is taken whenever
// that output register is empty or being emptied in the same cycle. The output
// of a tick is valid in the cycle after its input is taken. Configuration writes
// are taken at any time and should be done while no bus transaction is running.
// ----------------------------------------------------------------------------
module i2c_register_access_master_core
    import i2cram_pkg::*;
#(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    i2cram_in_if.sink     i_in,
    i2cram_out_if.source  o_out
);

    localparam int CMP_W = ((COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16) + 1;

    logic [15:0]              r_ticks_per_us;
    logic [15:0]              r_ack_limit;

    t_phase                   r_phase, n_phase;
    logic [COUNTER_WIDTH-1:0] r_delay, n_delay;
    logic [2:0]               r_usec, n_usec;
    logic [COUNTER_WIDTH-1:0] r_timeout, n_timeout;
    logic [3:0]               r_bit, n_bit;
    logic [1:0]               r_byte, n_byte;
    logic [7:0]               r_shift, n_shift;
    logic [6:0]               r_dev, n_dev;
    logic [7:0]               r_reg, n_reg;
    logic [7:0]               r_data, n_data;
    logic                     r_is_read, n_is_read;
    logic [7:0]               r_rx, n_rx;
    logic                     r_scl, n_scl;
    logic                     r_sda, n_sda;
    logic                     r_drv, n_drv;

    logic                     r_out_valid;
    t_out_payload             r_out;

    logic                     w_accept;
    logic                     v_enter;
    t_phase                   v_target;
    logic                     v_done;
    logic                     v_err;
    logic                     w_delay_end;
    logic                     w_timeout_fail;

    function automatic logic [7:0] byte_for(input logic [1:0] idx, input logic [6:0] dev,
                                            input logic [7:0] rega, input logic [7:0] dat,
                                            input logic rd);
        logic [7:0] b;
        case (idx)
            2'd0:    b = {dev, 1'b0};
            2'd1:    b = rega;
            2'd2:    b = rd ? {dev, 1'b1} : dat;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    assign w_accept   = i_in.valid && i_in.ready;
    assign i_in.ready = !r_out_valid || o_out.ready;

    // A zero tick rate ends every delay unit after one tick, like a rate of one.
    assign w_delay_end = ({{(CMP_W-COUNTER_WIDTH){1'b0}}, r_delay} + CMP_W'(1)
                          >= {{(CMP_W-16){1'b0}}, r_ticks_per_us})
                         || (r_delay == {COUNTER_WIDTH{1'b1}});
    assign w_timeout_fail = ({{(CMP_W-COUNTER_WIDTH){1'b0}}, r_timeout}
                             >= {{(CMP_W-16){1'b0}}, r_ack_limit})
                            || (r_timeout == {COUNTER_WIDTH{1'b1}});

    always_comb begin
        n_phase   = r_phase;
        n_delay   = r_delay;
        n_usec    = r_usec;
        n_timeout = r_timeout;
        n_bit     = r_bit;
        n_byte    = r_byte;
        n_shift   = r_shift;
        n_dev     = r_dev;
        n_reg     = r_reg;
        n_data    = r_data;
        n_is_read = r_is_read;
        n_rx      = r_rx;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_drv     = r_drv;
        v_enter   = 1'b0;
        v_target  = PH_IDLE;
        v_done    = 1'b0;
        v_err     = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (i_in.payload.kind == KIND_WRITE || i_in.payload.kind == KIND_READ) begin
                n_dev     = i_in.payload.device_address;
                n_reg     = i_in.payload.register_address;
                n_data    = i_in.payload.write_data;
                n_is_read = (i_in.payload.kind == KIND_READ);
                n_byte    = 2'd0;
                n_bit     = 4'd0;
                v_enter   = 1'b1;
                v_target  = PH_ST_HIGH;
            end
        end else if (r_phase == PH_ACK_POLL) begin
            if (i_in.payload.sda_in) begin
                if (w_timeout_fail) begin
                    v_enter  = 1'b1;
                    v_target = PH_SPE_LOW;
                end else begin
                    n_timeout = r_timeout + COUNTER_WIDTH'(1);
                end
            end else if (!r_is_read) begin
                if (r_byte < 2'd2) begin
                    n_byte   = r_byte + 2'd1;
                    n_shift  = byte_for(n_byte, r_dev, r_reg, r_data, r_is_read);
                    n_bit    = 4'd0;
                    v_enter  = 1'b1;
                    v_target = PH_TX_SETUP;
                end else begin
                    v_enter  = 1'b1;
                    v_target = PH_SP_LOW;
                end
            end else if (r_byte == 2'd0) begin
                n_byte   = 2'd1;
                n_shift  = byte_for(n_byte, r_dev, r_reg, r_data, r_is_read);
                n_bit    = 4'd0;
                v_enter  = 1'b1;
                v_target = PH_TX_SETUP;
            end else if (r_byte == 2'd1) begin
                n_byte   = 2'd2;
                v_enter  = 1'b1;
                v_target = PH_RS_PREP;
            end else begin
                n_byte   = 2'd3;
                n_bit    = 4'd0;
                n_shift  = 8'h00;
                v_enter  = 1'b1;
                v_target = PH_RX_LOW;
            end
        end else if (w_delay_end) begin
            n_delay = '0;
            if (r_usec != 3'd0) begin
                n_usec = r_usec - 3'd1;
            end
            if (n_usec == 3'd0) begin
                v_enter = 1'b1;
                unique case (r_phase)
                    PH_ST_HIGH:    v_target = PH_ST_LOW;
                    PH_ST_LOW: begin
                        n_shift  = byte_for(r_byte, r_dev, r_reg, r_data, r_is_read);
                        n_bit    = 4'd0;
                        v_target = PH_TX_SETUP;
                    end
                    PH_RS_PREP:    v_target = PH_ST_HIGH;
                    PH_TX_SETUP:   v_target = PH_TX_HIGH;
                    PH_TX_HIGH:    v_target = PH_TX_LOW;
                    PH_TX_LOW: begin
                        n_bit    = r_bit + 4'd1;
                        n_shift  = {r_shift[6:0], 1'b0};
                        v_target = (n_bit >= 4'd8) ? PH_ACK_REL : PH_TX_SETUP;
                    end
                    PH_ACK_REL:    v_target = PH_ACK_HIGH;
                    PH_ACK_HIGH:   v_target = PH_ACK_POLL;
                    PH_RX_LOW: begin
                        n_shift  = {r_shift[6:0], i_in.payload.sda_in};
                        n_bit    = r_bit + 4'd1;
                        v_target = PH_RX_HIGH;
                    end
                    PH_RX_HIGH: begin
                        if (r_bit >= 4'd8) begin
                            n_rx     = r_shift;
                            v_target = PH_NACK_SETUP;
                        end else begin
                            v_target = PH_RX_LOW;
                        end
                    end
                    PH_NACK_SETUP: v_target = PH_NACK_HIGH;
                    PH_NACK_HIGH:  v_target = PH_SP_LOW;
                    PH_SP_LOW:     v_target = PH_SP_HIGH;
                    PH_SP_HIGH:    v_target = PH_SP_DONE;
                    PH_SPE_LOW:    v_target = PH_SPE_HIGH;
                    PH_SPE_HIGH:   v_target = PH_SPE_DONE;
                    PH_SP_DONE, PH_SPE_DONE: begin
                        // End of the stop condition: the transaction is over.
                        v_enter = 1'b0;
                        v_done  = 1'b1;
                        v_err   = (r_phase == PH_SPE_DONE);
                        n_phase = PH_IDLE;
                        n_usec  = 3'd0;
                    end
                    default: begin
                        v_enter = 1'b0;
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end else begin
            n_delay = r_delay + COUNTER_WIDTH'(1);
        end

        if (v_enter) begin
            n_phase = v_target;
            n_delay = '0;
            unique case (v_target) inside
                PH_ST_HIGH: begin
                    {n_scl, n_sda, n_drv} = 3'b111; n_usec = 3'd4;
                end
                PH_ST_LOW: begin
                    {n_scl, n_sda, n_drv} = 3'b101; n_usec = 3'd4;
                end
                PH_RS_PREP: begin
                    {n_scl, n_sda, n_drv} = 3'b011; n_usec = 3'd2;
                end
                PH_TX_SETUP: begin
                    {n_scl, n_sda, n_drv} = {1'b0, n_shift[7], 1'b1}; n_usec = 3'd2;
                end
                PH_TX_HIGH: begin
                    {n_scl, n_sda, n_drv} = {1'b1, r_sda, 1'b1}; n_usec = 3'd2;
                end
                PH_TX_LOW: begin
                    {n_scl, n_sda, n_drv} = {1'b0, r_sda, 1'b1}; n_usec = 3'd2;
                end
                PH_ACK_REL: begin
                    {n_scl, n_sda, n_drv} = 3'b010; n_usec = 3'd1;
                end
                PH_ACK_HIGH: begin
                    {n_scl, n_sda, n_drv} = 3'b110; n_usec = 3'd1;
                end
                PH_ACK_POLL: begin
                    {n_scl, n_sda, n_drv} = 3'b110; n_usec = 3'd0; n_timeout = '0;
                end
                PH_RX_LOW: begin
                    {n_scl, n_sda, n_drv} = 3'b010; n_usec = 3'd2;
                end
                PH_RX_HIGH: begin
                    {n_scl, n_sda, n_drv} = 3'b110; n_usec = 3'd1;
                end
                PH_NACK_SETUP: begin
                    {n_scl, n_sda, n_drv} = 3'b011; n_usec = 3'd2;
                end
                PH_NACK_HIGH: begin
                    {n_scl, n_sda, n_drv} = 3'b111; n_usec = 3'd2;
                end
                PH_SP_LOW, PH_SPE_LOW: begin
                    {n_scl, n_sda, n_drv} = 3'b001; n_usec = 3'd4;
                end
                PH_SP_HIGH, PH_SPE_HIGH: begin
                    {n_scl, n_sda, n_drv} = 3'b101; n_usec = 3'd4;
                end
                PH_SP_DONE, PH_SPE_DONE: begin
                    {n_scl, n_sda, n_drv} = 3'b111; n_usec = 3'd4;
                end
                default: begin
                    n_usec = 3'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_us <= TICKS_PER_US_RESET;
            r_ack_limit    <= ACK_TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TICKS_PER_US: r_ticks_per_us <= i_cfg_data;
                CFG_ACK_TIMEOUT:  r_ack_limit    <= i_cfg_data;
                default:          r_ack_limit    <= r_ack_limit;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_delay   <= '0;
            r_usec    <= 3'd0;
            r_timeout <= '0;
            r_bit     <= 4'd0;
            r_byte    <= 2'd0;
            r_shift   <= 8'h00;
            r_dev     <= 7'h00;
            r_reg     <= 8'h00;
            r_data    <= 8'h00;
            r_is_read <= 1'b0;
            r_rx      <= 8'h00;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_drv     <= 1'b1;
        end else if (w_accept) begin
            r_phase   <= n_phase;
            r_delay   <= n_delay;
            r_usec    <= n_usec;
            r_timeout <= n_timeout;
            r_bit     <= n_bit;
            r_byte    <= n_byte;
            r_shift   <= n_shift;
            r_dev     <= n_dev;
            r_reg     <= n_reg;
            r_data    <= n_data;
            r_is_read <= n_is_read;
            r_rx      <= n_rx;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_drv     <= n_drv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out.scl_level        <= n_scl;
            r_out.sda_level        <= n_sda;
            r_out.sda_drive_enable <= n_drv;
            r_out.busy_res         <= (n_phase != PH_IDLE);
            r_out.done_res         <= v_done;
            r_out.ack_error        <= v_done && v_err;
            r_out.read_data        <= n_rx;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // The bus is left with SCL and SDA high and driven whenever no transaction runs.
    a_idle_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_scl && r_sda && r_drv))
        else $error("pins not released to idle levels");

    // The slave owns SDA while the acknowledge is polled.
    a_poll_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ACK_POLL) |-> (!r_drv && r_scl))
        else $error("SDA driven during acknowledge poll");

    // A finished transaction is reported with busy already low.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> !r_out.busy_res)
        else $error("done reported while busy");

    // An acknowledge error is only flagged together with done.
    a_err_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.ack_error) |-> r_out.done_res)
        else $error("ack error without done");

    // Ending a transaction moves the sequencer back to idle.
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && v_done) |=> (r_phase == PH_IDLE))
        else $error("sequencer not idle after transaction end");

endmodule
